// ===== rtl/core/gcgr_pkg.sv =====
// Shared types, constants and the linearisation table for the gamma-correct
// gradient ramp. No dependencies.
package gcgr_pkg;

  localparam int MaxKeys       = 8;
  localparam int PlaceFracBits = 12;
  localparam int PlaceW        = PlaceFracBits + 1;
  localparam int SlotW         = $clog2(MaxKeys);
  localparam int CountW        = 4;
  localparam int LinW          = 17;
  localparam int ProdW         = LinW + PlaceW;
  localparam int DivLat        = 3;
  localparam int ChanLat       = 7;
  localparam int SideDepth     = DivLat + ChanLat;

  localparam logic [PlaceW-1:0] PlaceOne = PlaceW'(1 << PlaceFracBits);
  localparam logic [CountW-1:0] MinKeys  = CountW'(2);
  localparam logic [CountW-1:0] TopKeys  = CountW'(MaxKeys);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e           opcode;
    logic [SlotW-1:0]  key_slot;
    logic [PlaceW-1:0] key_place;
    logic [7:0]        key_red;
    logic [7:0]        key_green;
    logic [7:0]        key_blue;
    logic [PlaceW-1:0] sample_place;
  } gcgr_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       span_missing;
  } gcgr_out_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic valid;
    logic bypass;
    logic missing;
    rgb_t ca;
    rgb_t cb;
  } side_t;

  typedef logic [LinW-1:0] lin_rom_t [256];

  // largest y with y^5 * 255^11 <= c^11 * 2^80
  function automatic lin_rom_t build_lin();
    lin_rom_t     rom;
    logic [191:0] a;
    logic [191:0] b;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    for (int c = 0; c < 256; c++) begin
      b = 192'd1;
      for (int i = 0; i < 11; i++) b = b * 192'(c);
      b = b << 80;
      lo = 0;
      hi = 65536;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        a = 192'd1;
        for (int i = 0; i < 5; i++) a = a * 192'(mid);
        for (int i = 0; i < 11; i++) a = a * 192'd255;
        if (a <= b) lo = mid;
        else hi = mid - 1;
      end
      rom[c] = LinW'(lo);
    end
    return rom;
  endfunction

  localparam lin_rom_t LinRom = build_lin();

endpackage

// ===== rtl/core/gamma_correct_gradient_ramp_unit.sv =====
// Top level of the gamma-correct gradient ramp.
// Depends on gcgr_pkg, gcgr_span_sel, gcgr_alpha_div and gcgr_chan_mix.
//
// Usage:
//   An item is taken at a clock edge with start high and busy low; busy is
//   always low, so one item may enter every cycle. A write item (opcode 0)
//   stores a stop and gives no result; it is seen by every later item.
//   An evaluate item (opcode 1) gives one result on result_o, marked by
//   done_o for exactly one cycle; on its way the item passes through span
//   search, then division, then channel mixing.
//   Throughput is one item per cycle, set by the fully pipelined datapath.
//   Results leave in the order the items came in; the receiver cannot stall.
//   cfg_we_i/cfg_wdata_i write the active stop count, write it only while
//   no evaluate item is in flight.
//   Reset sets two active stops, black at 0.0 and white at 1.0, other
//   stops zero, and drops all items in flight.
module gamma_correct_gradient_ramp_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  gcgr_pkg::gcgr_in_t            item_i,
  input  logic                          cfg_we_i,
  input  logic [gcgr_pkg::CountW-1:0]   cfg_wdata_i,
  output logic                          done_o,
  output gcgr_pkg::gcgr_out_t           result_o
);
  import gcgr_pkg::*;

  logic [CountW-1:0] active_keys_q;
  side_t             span_side;
  side_t             side_q [SideDepth];
  logic [PlaceW-1:0] num, den, alpha;
  rgb_t              mixed;
  side_t             fin;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_keys_q <= MinKeys;
    end else if (cfg_we_i) begin
      active_keys_q <= cfg_wdata_i;
    end
  end

  gcgr_span_sel u_span (
    .clk_i,
    .rst_ni,
    .take_i        (start && !busy),
    .item_i,
    .active_keys_i (active_keys_q),
    .side_o        (span_side),
    .num_o         (num),
    .den_o         (den)
  );

  gcgr_alpha_div u_div (
    .clk_i,
    .num_i   (num),
    .den_i   (den),
    .alpha_o (alpha)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SideDepth; i++) side_q[i] <= '0;
    end else begin
      side_q[0] <= span_side;
      for (int i = 1; i < SideDepth; i++) side_q[i] <= side_q[i-1];
    end
  end

  gcgr_chan_mix u_mix_r (
    .clk_i, .ca_i(side_q[DivLat-1].ca.r), .cb_i(side_q[DivLat-1].cb.r),
    .alpha_i(alpha), .code_o(mixed.r)
  );

  gcgr_chan_mix u_mix_g (
    .clk_i, .ca_i(side_q[DivLat-1].ca.g), .cb_i(side_q[DivLat-1].cb.g),
    .alpha_i(alpha), .code_o(mixed.g)
  );

  gcgr_chan_mix u_mix_b (
    .clk_i, .ca_i(side_q[DivLat-1].ca.b), .cb_i(side_q[DivLat-1].cb.b),
    .alpha_i(alpha), .code_o(mixed.b)
  );

  assign fin    = side_q[SideDepth-1];
  assign done_o = fin.valid;

  always_comb begin
    result_o.span_missing = fin.missing;
    if (fin.bypass) begin
      result_o.out_red   = fin.ca.r;
      result_o.out_green = fin.ca.g;
      result_o.out_blue  = fin.ca.b;
    end else begin
      result_o.out_red   = mixed.r;
      result_o.out_green = mixed.g;
      result_o.out_blue  = mixed.b;
    end
  end

endmodule

// ===== rtl/core/gcgr_span_sel.sv =====
// Stop store and span search: first pipeline stage of the gradient ramp.
// Depends on gcgr_pkg.
module gcgr_span_sel (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      take_i,
  input  gcgr_pkg::gcgr_in_t        item_i,
  input  logic [gcgr_pkg::CountW-1:0] active_keys_i,
  output gcgr_pkg::side_t           side_o,
  output logic [gcgr_pkg::PlaceW-1:0] num_o,
  output logic [gcgr_pkg::PlaceW-1:0] den_o
);
  import gcgr_pkg::*;

  logic [PlaceW-1:0] place_q [MaxKeys];
  rgb_t              colour_q [MaxKeys];
  side_t             side_q, side_d;
  logic [PlaceW-1:0] num_q, num_d, den_q, den_d;
  logic [CountW-1:0] n_eff;
  logic [PlaceW-1:0] p, pa, pb;
  rgb_t              ca, cb, last_c;
  logic              found;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxKeys; k++) begin
        place_q[k]  <= '0;
        colour_q[k] <= '0;
      end
      place_q[1]  <= PlaceOne;
      colour_q[1] <= '1;
    end else if (take_i && item_i.opcode == OP_WRITE) begin
      place_q[item_i.key_slot]  <= item_i.key_place;
      colour_q[item_i.key_slot] <= '{r: item_i.key_red, g: item_i.key_green,
                                     b: item_i.key_blue};
    end
  end

  always_comb begin
    if (active_keys_i < MinKeys) n_eff = MinKeys;
    else if (active_keys_i > TopKeys) n_eff = TopKeys;
    else n_eff = active_keys_i;
    p      = item_i.sample_place;
    found  = 1'b0;
    pa     = '0;
    pb     = '0;
    ca     = colour_q[0];
    cb     = colour_q[0];
    last_c = colour_q[0];
    for (int k = MaxKeys - 1; k >= 0; k--) begin
      if (k == int'(n_eff) - 1) last_c = colour_q[k];
    end
    for (int k = MaxKeys - 2; k >= 0; k--) begin
      if (k + 1 < int'(n_eff) && place_q[k] <= p && place_q[k+1] >= p) begin
        found = 1'b1;
        pa    = place_q[k];
        pb    = place_q[k+1];
        ca    = colour_q[k];
        cb    = colour_q[k+1];
      end
    end
    side_d.valid   = take_i && item_i.opcode == OP_EVAL;
    side_d.bypass  = 1'b1;
    side_d.missing = 1'b0;
    side_d.ca      = ca;
    side_d.cb      = cb;
    num_d          = p - pa;
    den_d          = pb - pa;
    priority if (p == '0) begin
      side_d.ca = colour_q[0];
    end else if (p >= PlaceOne) begin
      side_d.ca = last_c;
    end else if (!found) begin
      side_d.ca      = colour_q[0];
      side_d.missing = 1'b1;
    end else if (pa != pb) begin
      side_d.bypass = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else begin
      side_q <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
  end

  assign side_o = side_q;
  assign num_o  = num_q;
  assign den_o  = den_q;

endmodule

// ===== rtl/core/gcgr_alpha_div.sv =====
// Three-stage restoring divider for the span fraction, four or five bits a
// stage. Depends on gcgr_pkg.
module gcgr_alpha_div (
  input  logic                        clk_i,
  input  logic [gcgr_pkg::PlaceW-1:0] num_i,
  input  logic [gcgr_pkg::PlaceW-1:0] den_i,
  output logic [gcgr_pkg::PlaceW-1:0] alpha_o
);
  import gcgr_pkg::*;

  logic [PlaceW-1:0] r1_q, r1_d, d1_q, r2_q, r2_d, d2_q, r3;
  logic [3:0]        q1_q, q1_d;
  logic [8:0]        q2_q, q2_d;
  logic [PlaceW-1:0] alpha_q, alpha_d;

  function automatic logic [PlaceW:0] step(input logic [PlaceW-1:0] r,
                                           input logic [PlaceW-1:0] d);
    logic [PlaceW:0] t;
    t = {r, 1'b0};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
      return {1'b1, t[PlaceW-1:0]};
    end
    return {1'b0, t[PlaceW-1:0]};
  endfunction

  always_comb begin
    logic [PlaceW:0] s;
    r1_d    = num_i;
    q1_d    = '0;
    q1_d[3] = num_i >= den_i;
    if (q1_d[3]) r1_d = num_i - den_i;
    for (int i = 2; i >= 0; i--) begin
      s       = step(r1_d, den_i);
      q1_d[i] = s[PlaceW];
      r1_d    = s[PlaceW-1:0];
    end
    r2_d = r1_q;
    q2_d = {q1_q, 5'd0};
    for (int i = 4; i >= 0; i--) begin
      s       = step(r2_d, d1_q);
      q2_d[i] = s[PlaceW];
      r2_d    = s[PlaceW-1:0];
    end
    r3      = r2_q;
    alpha_d = {q2_q, 4'd0};
    for (int i = 3; i >= 0; i--) begin
      s          = step(r3, d2_q);
      alpha_d[i] = s[PlaceW];
      r3         = s[PlaceW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q    <= r1_d;
    d1_q    <= den_i;
    q1_q    <= q1_d;
    r2_q    <= r2_d;
    d2_q    <= d1_q;
    q2_q    <= q2_d;
    alpha_q <= alpha_d;
  end

  assign alpha_o = alpha_q;

endmodule

// ===== rtl/core/gcgr_chan_mix.sv =====
// One colour channel: linearise, weight, round, then re-encode by a pipelined
// binary search of the table. Depends on gcgr_pkg.
module gcgr_chan_mix (
  input  logic                        clk_i,
  input  logic [7:0]                  ca_i,
  input  logic [7:0]                  cb_i,
  input  logic [gcgr_pkg::PlaceW-1:0] alpha_i,
  output logic [7:0]                  code_o
);
  import gcgr_pkg::*;

  logic [ProdW-1:0]  pa_q, pb_q;
  logic [ProdW:0]    sum;
  logic [LinW-1:0]   srch_l_q [5];
  logic [7:0]        srch_c_q [5];
  logic [7:0]        code_q, code_d;
  logic [LinW-1:0]   lo_v, hi_v;

  always_ff @(posedge clk_i) begin
    pa_q <= ProdW'(LinRom[ca_i]) * ProdW'(PlaceOne - alpha_i);
    pb_q <= ProdW'(LinRom[cb_i]) * ProdW'(alpha_i);
  end

  assign sum = {1'b0, pa_q} + {1'b0, pb_q} + (ProdW + 1)'(PlaceOne >> 1);

  always_ff @(posedge clk_i) begin
    srch_l_q[0] <= sum[PlaceFracBits +: LinW];
    srch_c_q[0] <= '0;
  end

  for (genvar g = 0; g < 4; g++) begin : g_srch
    logic [7:0] c_d;
    always_comb begin
      logic [7:0] t;
      c_d = srch_c_q[g];
      t   = c_d | 8'(1 << (7 - 2 * g));
      if (LinRom[t] <= srch_l_q[g]) c_d = t;
      t   = c_d | 8'(1 << (6 - 2 * g));
      if (LinRom[t] <= srch_l_q[g]) c_d = t;
    end
    always_ff @(posedge clk_i) begin
      srch_l_q[g+1] <= srch_l_q[g];
      srch_c_q[g+1] <= c_d;
    end
  end

  always_comb begin
    code_d = srch_c_q[4];
    lo_v   = LinRom[srch_c_q[4]];
    hi_v   = LinRom[srch_c_q[4] + 8'd1];
    if (srch_c_q[4] != 8'hFF && (hi_v - srch_l_q[4]) < (srch_l_q[4] - lo_v)) begin
      code_d = srch_c_q[4] + 8'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  assign code_o = code_q;

endmodule

// ===== bench/tb_gamma_correct_gradient_ramp_unit.sv =====
// Testbench for the gamma-correct gradient ramp: random and directed stop
// writes and evaluations, checked against an in-bench colour predictor.
// Depends on gcgr_pkg and gamma_correct_gradient_ramp_unit.
`timescale 1ns / 1ps

module tb_gamma_correct_gradient_ramp_unit;
  import gcgr_pkg::*;

  typedef struct packed {
    logic             is_cfg;
    logic [CountW-1:0] keys;
    gcgr_in_t         item;
  } job_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  gcgr_in_t            item_i = '0;
  logic                cfg_we_i = 1'b0;
  logic [CountW-1:0]   cfg_wdata_i = '0;
  logic                done_o;
  gcgr_out_t           result_o;

  job_t        pending_jobs[$];
  gcgr_out_t   expected_colours[$];
  logic [PlaceW-1:0] stop_place[MaxKeys];
  rgb_t        stop_colour[MaxKeys];
  logic [CountW-1:0] keys_in_use;
  int unsigned lin_tab[256];
  int          mismatches = 0;
  int          quiet_until = 0;
  int          cyc = 0;
  logic        feeding_done = 1'b0;

  gamma_correct_gradient_ramp_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i), .done_o(done_o),
    .result_o(result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned lin_of(int unsigned c);
    logic [191:0] a;
    logic [191:0] b;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    b = 192'd1;
    for (int i = 0; i < 11; i++) b = b * 192'(c);
    b = b << 80;
    lo = 0;
    hi = 65536;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      a = 192'd1;
      for (int i = 0; i < 5; i++) a = a * 192'(mid);
      for (int i = 0; i < 11; i++) a = a * 192'd255;
      if (a <= b) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic logic [7:0] mix_code(logic [7:0] ca, logic [7:0] cb,
                                          longint unsigned alpha);
    longint unsigned s;
    int unsigned     l;
    int unsigned     c;
    s = longint'(lin_tab[ca]) * (4096 - alpha) + longint'(lin_tab[cb]) * alpha + 2048;
    l = 32'(s >> PlaceFracBits);
    c = 0;
    for (int k = 1; k < 256; k++) if (lin_tab[k] <= l) c = k;
    if (c < 255 && (lin_tab[c+1] - l) < (l - lin_tab[c])) c++;
    return c[7:0];
  endfunction

  function automatic gcgr_out_t predict_colour(logic [PlaceW-1:0] p);
    int        n;
    gcgr_out_t r;
    longint unsigned alpha;
    n = keys_in_use;
    if (n < 2) n = 2;
    if (n > MaxKeys) n = MaxKeys;
    if (p == 0) return {stop_colour[0], 1'b0};
    if (p >= PlaceOne) return {stop_colour[n-1], 1'b0};
    for (int k = 0; k + 1 < n; k++) begin
      if (stop_place[k] <= p && stop_place[k+1] >= p) begin
        if (stop_place[k] == stop_place[k+1]) return {stop_colour[k], 1'b0};
        alpha = (longint'(p - stop_place[k]) << PlaceFracBits)
                / (stop_place[k+1] - stop_place[k]);
        r.out_red   = mix_code(stop_colour[k].r, stop_colour[k+1].r, alpha);
        r.out_green = mix_code(stop_colour[k].g, stop_colour[k+1].g, alpha);
        r.out_blue  = mix_code(stop_colour[k].b, stop_colour[k+1].b, alpha);
        r.span_missing = 1'b0;
        return r;
      end
    end
    return {stop_colour[0], 1'b1};
  endfunction

  function automatic gcgr_in_t rand_item(logic eval);
    gcgr_in_t it;
    it.opcode = eval ? OP_EVAL : OP_WRITE;
    it.key_slot = SlotW'($urandom_range(7, 0));
    it.key_place = PlaceW'($urandom);
    it.key_red = 8'($urandom);
    it.key_green = 8'($urandom);
    it.key_blue = 8'($urandom);
    it.sample_place = PlaceW'(($urandom_range(9, 0) == 0) ? PlaceOne + $urandom_range(4095, 0)
                                                          : $urandom_range(4096, 0));
    return it;
  endfunction

  task automatic add_job(logic is_cfg, logic [CountW-1:0] keys, gcgr_in_t it);
    job_t j;
    j.is_cfg = is_cfg;
    j.keys = keys;
    j.item = it;
    pending_jobs.push_back(j);
  endtask

  task automatic add_sorted_stops(int n);
    int unsigned pos;
    gcgr_in_t    it;
    pos = 0;
    for (int k = 0; k < n; k++) begin
      it = rand_item(1'b0);
      it.key_slot = SlotW'(k);
      if (k == 0) pos = $urandom_range(200, 0);
      else if ($urandom_range(7, 0) == 0) pos = pos;
      else pos = pos + $urandom_range(4096 / n + 200, 1);
      if (k == n - 1 && $urandom_range(1, 0)) pos = 4096;
      if (pos > 4096) pos = 4096;
      it.key_place = PlaceW'(pos);
      add_job(1'b0, '0, it);
    end
  endtask

  always @(negedge clk_i) begin
    job_t j;
    logic start_d;
    logic we_d;
    start_d = start && busy;
    we_d = 1'b0;
    cyc <= cyc + 1;
    if (rst_ni && pending_jobs.size() > 0 && !(start && busy)) begin
      j = pending_jobs[0];
      if (j.is_cfg) begin
        if (expected_colours.size() == 0 && !(start && !busy) && cyc >= quiet_until) begin
          void'(pending_jobs.pop_front());
          we_d = 1'b1;
          cfg_wdata_i <= j.keys;
          keys_in_use = j.keys;
        end
      end else if ((cyc % 1000 < 300) || $urandom_range(99, 0) >= 13) begin
        void'(pending_jobs.pop_front());
        start_d = 1'b1;
        item_i <= j.item;
        if (j.item.opcode == OP_EVAL) begin
          expected_colours.push_back(predict_colour(j.item.sample_place));
          quiet_until <= cyc + 40;
        end else if (j.item.key_slot < MaxKeys) begin
          stop_place[j.item.key_slot] = j.item.key_place;
          stop_colour[j.item.key_slot] = {j.item.key_red, j.item.key_green, j.item.key_blue};
          quiet_until <= cyc + 40;
        end
      end
    end else if (rst_ni && pending_jobs.size() == 0 && !(start && busy)) begin
      feeding_done <= 1'b1;
    end
    start <= start_d;
    cfg_we_i <= we_d;
  end

  always @(posedge clk_i) begin
    gcgr_out_t want;
    if (rst_ni && done_o) begin
      if (expected_colours.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result_o);
      end else begin
        want = expected_colours.pop_front();
        if (want !== result_o) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h actual %h", want, result_o);
        end
      end
    end
  end

  initial begin
    gcgr_in_t it;
    int       n;
    for (int c = 0; c < 256; c++) lin_tab[c] = lin_of(c);
    for (int k = 0; k < MaxKeys; k++) begin
      stop_place[k] = '0;
      stop_colour[k] = '0;
    end
    stop_place[1] = PlaceOne;
    stop_colour[1] = 24'hFFFFFF;
    keys_in_use = MinKeys;
    it = rand_item(1'b1);
    it.sample_place = PlaceW'(0);    add_job(1'b0, '0, it);
    it.sample_place = PlaceW'(4096); add_job(1'b0, '0, it);
    it.sample_place = PlaceW'(2048); add_job(1'b0, '0, it);
    it.sample_place = PlaceW'(8191); add_job(1'b0, '0, it);
    it.sample_place = PlaceW'(1);    add_job(1'b0, '0, it);
    it.sample_place = PlaceW'(4095); add_job(1'b0, '0, it);
    add_job(1'b1, 4'd0, it);
    add_job(1'b1, 4'd15, it);
    it.sample_place = PlaceW'(1000); add_job(1'b0, '0, it);
    add_job(1'b1, 4'd4, it);
    it = rand_item(1'b0);
    it.key_slot = SlotW'(2); it.key_place = PlaceW'(3000); add_job(1'b0, '0, it);
    it.key_slot = SlotW'(3); it.key_place = PlaceW'(3000); add_job(1'b0, '0, it);
    it.key_slot = SlotW'(1); it.key_place = PlaceW'(8191); add_job(1'b0, '0, it);
    it = rand_item(1'b1);
    it.sample_place = PlaceW'(3000); add_job(1'b0, '0, it);
    it.sample_place = PlaceW'(2000); add_job(1'b0, '0, it);
    it.sample_place = PlaceW'(4000); add_job(1'b0, '0, it);
    it.sample_place = PlaceW'(4096); add_job(1'b0, '0, it);
    add_job(1'b1, 4'd2, it);
    add_job(1'b1, 4'd8, it);
    for (int ph = 0; ph < 40; ph++) begin
      n = (ph % 5 == 0) ? 8 : $urandom_range(8, 2);
      if (ph % 7 == 3) n = 2;
      add_job(1'b1, $urandom_range(6, 0) == 0 ? 4'($urandom_range(15, 0)) : 4'(n), it);
      if ($urandom_range(4, 0) != 0) add_sorted_stops(n);
      for (int i = 0; i < 45; i++) begin
        it = rand_item($urandom_range(9, 0) != 0);
        add_job(1'b0, '0, it);
      end
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    wait (feeding_done && expected_colours.size() == 0);
    repeat (30) @(posedge clk_i);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/gcgr_pkg.sv
rtl/core/gcgr_span_sel.sv
rtl/core/gcgr_alpha_div.sv
rtl/core/gcgr_chan_mix.sv
rtl/core/gamma_correct_gradient_ramp_unit.sv
bench/tb_gamma_correct_gradient_ramp_unit.sv
